/* hw/rtl/magr_pkg.sv */
package magr_pkg;

    localparam int unsigned GRAVITY_Q16 = 642908;
    localparam int unsigned TAU_RESET   = 8500;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic        [19:0] step_us;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic signed [31:0] body_z;
        logic signed [31:0] earth_x;
        logic signed [31:0] earth_y;
        logic signed [31:0] earth_z;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [33:0] rclamp(input logic signed [35:0] v);
        if (v > 36'sd2147483648)
            return 34'sd2147483648;
        else if (v < -36'sd2147483648)
            return -34'sd2147483648;
        else
            return v[33:0];
    endfunction

endpackage

/* hw/rtl/magr_mul.sv */
module magr_mul
(
    input  logic               clk,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic signed [67:0] p
);

    logic signed [67:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* hw/rtl/magr_div.sv */
module magr_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic        [70:0] num_mag,
    input  logic        [20:0] den,
    output logic               done,
    output logic        [70:0] quo
);

    logic [70:0] q_reg, q_next;
    logic [21:0] r_reg, r_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [21:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[20:0], q_reg[70]};
        if (start)
        begin
            q_next    = num_mag;
            r_next    = '0;
            cnt_next  = 7'd71;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[69:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[69:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* hw/rtl/motion_accel_gravity_removal.sv */
// The divisions are skipped when tau + step is zero.
// One shared 34x34 multiplier runs 27 products in turn; the
// three 71-step serial divisions run one after another on a single divider.
// A new request is taken only once the previous result has been accepted;
// s_axis_tready is high only while idle, result held until taken.
// Reset (rst_n, async, active low): filter state zero, tau 8500 us.
module motion_accel_gravity_removal
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z, step_us, 4'b0
    input  logic [247:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // motion_body_x/y/z, motion_earth_x/y/z
    output logic [191:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [19:0]  cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_QP   = 7'b0000010,
        ST_GB   = 7'b0000100,
        ST_FM   = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_EM   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [19:0] tau_reg;
    logic signed [31:0] filt_reg [3];
    logic signed [31:0] a_reg [3];
    logic signed [31:0] q_reg [4];
    logic [19:0] dt_reg;
    logic signed [33:0] r_reg [9];
    logic signed [33:0] p_reg [9];
    logic signed [33:0] d_reg [3];
    logic signed [71:0] acc_reg;
    logic signed [35:0] e_reg [3];
    logic [5:0] idx_reg;
    logic       ph_reg;
    logic       dstart_reg;
    logic signed [31:0] ob_reg [3];
    logic signed [31:0] oe_reg [3];

    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    logic [70:0] dquo;
    logic        ddone;
    logic [20:0] den;
    logic        neg;
    logic [70:0] nmag;

    // quaternion product pairs
    logic [1:0] qa, qb;
    logic signed [67:0] rnd;
    logic signed [33:0] pq;
    logic signed [37:0] term;
    logic [1:0] ii, jj;

    assign den  = {1'b0, tau_reg} + {1'b0, dt_reg};
    assign neg  = acc_reg[71];
    assign nmag = neg ? 71'(-acc_reg) : acc_reg[70:0];

    magr_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
    magr_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart_reg),
                    .num_mag(nmag + 71'(den >> 1)), .den(den),
                    .done(ddone), .quo(dquo));

    assign rnd  = mp + (68'sd1 <<< 29);
    assign pq   = rnd[63:30];
    assign term = rnd[67:30];

    always_comb
    begin
        qa = 2'd0; qb = 2'd0; ma = '0; mb = '0;
        if (idx_reg >= 6'd6)
        begin
            ii = 2'd2; jj = 2'(idx_reg - 6'd6);
        end
        else if (idx_reg >= 6'd3)
        begin
            ii = 2'd1; jj = 2'(idx_reg - 6'd3);
        end
        else
        begin
            ii = 2'd0; jj = idx_reg[1:0];
        end
        case (idx_reg[3:0])
            4'd0: begin qa = 2'd1; qb = 2'd1; end
            4'd1: begin qa = 2'd2; qb = 2'd2; end
            4'd2: begin qa = 2'd3; qb = 2'd3; end
            4'd3: begin qa = 2'd1; qb = 2'd2; end
            4'd4: begin qa = 2'd1; qb = 2'd3; end
            4'd5: begin qa = 2'd2; qb = 2'd3; end
            4'd6: begin qa = 2'd0; qb = 2'd1; end
            4'd7: begin qa = 2'd0; qb = 2'd2; end
            default: begin qa = 2'd0; qb = 2'd3; end
        endcase
        case (state_reg)
            ST_QP:
            begin
                ma = 34'(q_reg[qa]);
                mb = 34'(q_reg[qb]);
            end
            ST_GB:
            begin
                ma = r_reg[4'd6 + 4'(idx_reg[1:0])];
                mb = 34'(magr_pkg::GRAVITY_Q16);
            end
            ST_FM:
            begin
                if (idx_reg[0])
                begin
                    ma = 34'(filt_reg[idx_reg[2:1]]);
                    mb = 34'(tau_reg);
                end
                else
                begin
                    ma = d_reg[idx_reg[2:1]];
                    mb = 34'(dt_reg);
                end
            end
            ST_EM:
            begin
                ma = r_reg[idx_reg[3:0]];
                mb = 34'(filt_reg[jj]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tau_reg    <= 20'(magr_pkg::TAU_RESET);
            filt_reg   <= '{default: '0};
            idx_reg    <= '0;
            ph_reg     <= 1'b0;
            dstart_reg <= 1'b0;
        end
        else
        begin
            dstart_reg <= (state_reg == ST_FM) && ph_reg && idx_reg[0] && (den != '0);
            if (cfg_valid && cfg_ready)
                tau_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        idx_reg <= '0; ph_reg <= 1'b0;
                        state_reg <= ST_QP;
                    end
                end
                ST_QP:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        p_reg[idx_reg[3:0]] <= pq;
                        if (idx_reg == 6'd8)
                        begin
                            idx_reg <= '0;
                            state_reg <= ST_GB;
                        end
                        else
                            idx_reg <= idx_reg + 6'd1;
                    end
                end
                ST_GB:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        d_reg[idx_reg[1:0]] <= 34'(a_reg[idx_reg[1:0]]) - 34'(term);
                        if (idx_reg == 6'd2)
                        begin
                            idx_reg <= '0; acc_reg <= '0;
                            state_reg <= ST_FM;
                        end
                        else
                            idx_reg <= idx_reg + 6'd1;
                    end
                end
                ST_FM:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (idx_reg[0])
                        begin
                            if (den == '0)
                            begin
                                filt_reg[idx_reg[2:1]] <=
                                    magr_pkg::sat32(72'(d_reg[idx_reg[2:1]]));
                                acc_reg <= '0;
                                if (idx_reg == 6'd5)
                                begin
                                    idx_reg <= '0; state_reg <= ST_EM;
                                end
                                else
                                    idx_reg <= idx_reg + 6'd1;
                            end
                            else
                            begin
                                acc_reg <= acc_reg + 72'(mp);
                                state_reg <= ST_DIV;
                            end
                        end
                        else
                        begin
                            acc_reg <= acc_reg + 72'(mp);
                            idx_reg <= idx_reg + 6'd1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (ddone)
                    begin
                        filt_reg[idx_reg[2:1]] <= magr_pkg::sat32(neg ?
                            -$signed({1'b0, dquo}) : $signed({1'b0, dquo}));
                        acc_reg <= '0; ph_reg <= 1'b0;
                        if (idx_reg == 6'd5)
                        begin
                            idx_reg <= '0; state_reg <= ST_EM;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 6'd1; state_reg <= ST_FM;
                        end
                    end
                end
                ST_EM:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (jj == 2'd2)
                        begin
                            e_reg[ii] <= '0;
                            oe_reg[ii] <= magr_pkg::sat32(72'(e_reg[ii]) + 72'(term));
                        end
                        else if (jj == 2'd0)
                            e_reg[ii] <= 36'(term);
                        else
                            e_reg[ii] <= e_reg[ii] + 36'(term);
                        if (idx_reg == 6'd8)
                        begin
                            ob_reg <= filt_reg;
                            state_reg <= ST_OUT;
                        end
                        else
                            idx_reg <= idx_reg + 6'd1;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload capture and matrix build
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            a_reg[0] <= s_axis_tdata[31:0];
            a_reg[1] <= s_axis_tdata[63:32];
            a_reg[2] <= s_axis_tdata[95:64];
            q_reg[0] <= s_axis_tdata[127:96];
            q_reg[1] <= s_axis_tdata[159:128];
            q_reg[2] <= s_axis_tdata[191:160];
            q_reg[3] <= s_axis_tdata[223:192];
            dt_reg   <= s_axis_tdata[243:224];
        end
        if (state_reg == ST_QP && ph_reg && idx_reg == 6'd8)
        begin
            // p order: xx yy zz xy xz yz wx wy wz (wz from multiplier now)
            r_reg[0] <= magr_pkg::rclamp((36'sd1 <<< 30) -
                                         36'sd2 * (36'(p_reg[1]) + 36'(p_reg[2])));
            r_reg[1] <= magr_pkg::rclamp(36'sd2 * (36'(p_reg[3]) - 36'(pq)));
            r_reg[2] <= magr_pkg::rclamp(36'sd2 * (36'(p_reg[4]) + 36'(p_reg[7])));
            r_reg[3] <= magr_pkg::rclamp(36'sd2 * (36'(p_reg[3]) + 36'(pq)));
            r_reg[4] <= magr_pkg::rclamp((36'sd1 <<< 30) -
                                         36'sd2 * (36'(p_reg[0]) + 36'(p_reg[2])));
            r_reg[5] <= magr_pkg::rclamp(36'sd2 * (36'(p_reg[5]) - 36'(p_reg[6])));
            r_reg[6] <= magr_pkg::rclamp(36'sd2 * (36'(p_reg[4]) - 36'(p_reg[7])));
            r_reg[7] <= magr_pkg::rclamp(36'sd2 * (36'(p_reg[5]) + 36'(p_reg[6])));
            r_reg[8] <= magr_pkg::rclamp((36'sd1 <<< 30) -
                                         36'sd2 * (36'(p_reg[0]) + 36'(p_reg[1])));
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign cfg_ready     = 1'b1;
    assign m_axis_tdata  = {oe_reg[2], oe_reg[1], oe_reg[0], ob_reg[2], ob_reg[1], ob_reg[0]};

endmodule

/* bench/magr_checker.sv */
module magr_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [247:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [19:0]  cfg_data,
    output int           pending,
    output int           mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint RLIM    = 64'sd1 <<< 31;

    logic [19:0]   tau_us;
    longint        lp_state [3];
    logic [191:0]  motion_q [$];

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_i32(input longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint div_nearest(input longint num, input longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag + longint'(den) / 2) / longint'(den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_motion(input logic [247:0] d);
        longint acc [3];
        longint r [3][3];
        longint w, x, y, z, dt, den, gb, diff, e;
        longint pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
        logic [191:0] res;
        acc[0] = longint'($signed(d[31:0]));
        acc[1] = longint'($signed(d[63:32]));
        acc[2] = longint'($signed(d[95:64]));
        w = longint'($signed(d[127:96]));
        x = longint'($signed(d[159:128]));
        y = longint'($signed(d[191:160]));
        z = longint'($signed(d[223:192]));
        dt = longint'(d[243:224]);
        den = longint'(tau_us) + dt;
        pxx = round_q30(x * x); pyy = round_q30(y * y); pzz = round_q30(z * z);
        pxy = round_q30(x * y); pxz = round_q30(x * z); pyz = round_q30(y * z);
        pwx = round_q30(w * x); pwy = round_q30(w * y); pwz = round_q30(w * z);
        r[0][0] = ONE_Q30 - 2 * (pyy + pzz);
        r[0][1] = 2 * (pxy - pwz);
        r[0][2] = 2 * (pxz + pwy);
        r[1][0] = 2 * (pxy + pwz);
        r[1][1] = ONE_Q30 - 2 * (pxx + pzz);
        r[1][2] = 2 * (pyz - pwx);
        r[2][0] = 2 * (pxz - pwy);
        r[2][1] = 2 * (pyz + pwx);
        r[2][2] = ONE_Q30 - 2 * (pxx + pyy);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i][j] = clip(r[i][j], -RLIM, RLIM);
        for (int i = 0; i < 3; i++)
        begin
            gb = round_q30(r[2][i] * longint'(magr_pkg::GRAVITY_Q16));
            diff = acc[i] - gb;
            if (den == 0)
                lp_state[i] = sat_i32(diff);
            else
                lp_state[i] = sat_i32(div_nearest(diff * dt + lp_state[i] * longint'(tau_us),
                                                  den));
        end
        for (int i = 0; i < 3; i++)
        begin
            e = 0;
            for (int j = 0; j < 3; j++)
                e += round_q30(r[i][j] * lp_state[j]);
            res[32*i +: 32] = lp_state[i][31:0];
            res[32*(i+3) +: 32] = 32'(sat_i32(e));
        end
        motion_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_us = 20'(magr_pkg::TAU_RESET);
            for (int i = 0; i < 3; i++)
                lp_state[i] = 0;
            motion_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tau_us = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (motion_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    logic [191:0] exp_r;
                    exp_r = motion_q.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (exp_r[32*f +: 32] !== m_axis_tdata[32*f +: 32])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("field %0d: expected %h, got %h", f,
                                         exp_r[32*f +: 32], m_axis_tdata[32*f +: 32]);
                        end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_motion(s_axis_tdata);
        end
        pending = motion_q.size();
    end

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [247:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [19:0]  cfg_data = '0;
    int           pending;
    int           mismatches;
    bit           idle_on = 1'b1;
    int           hold_cycles = 0;

    localparam int Q_ONE = 32'sh40000000;

    always #1 clk = ~clk;

    motion_accel_gravity_removal DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    magr_checker u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .pending(pending), .mismatches(mismatches)
    );

    task automatic send_sample(input logic [31:0] ax, input logic [31:0] ay,
                               input logic [31:0] az, input logic [31:0] qw,
                               input logic [31:0] qx, input logic [31:0] qy,
                               input logic [31:0] qz, input logic [19:0] dt);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, dt, qz, qy, qx, qw, az, ay, ax};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_tau(input logic [19:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_accel();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
        endcase
    endfunction

    function automatic logic [31:0] rand_quat();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2 * Q_ONE)) - Q_ONE) >>> 1;
        endcase
    endfunction

    function automatic logic [19:0] rand_step();
        case ($urandom_range(0, 9))
            0: return 20'($urandom);
            1: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
            default: return 20'($urandom_range(200, 5000));
        endcase
    endfunction

    task automatic send_random(input int n);
        for (int k = 0; k < n; k++)
            send_sample(rand_accel(), rand_accel(), rand_accel(),
                        rand_quat(), rand_quat(), rand_quat(), rand_quat(), rand_step());
    endtask

    task automatic send_directed();
        send_sample(0, 0, 642908, Q_ONE, 0, 0, 0, 1000);
        send_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, Q_ONE, 0, 0, 0, 20'hFFFFF);
        send_sample(32'h80000000, 32'h80000000, 32'h80000000, Q_ONE, 0, 0, 0, 20'hFFFFF);
        send_sample(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 1);
        send_sample(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 20'hFFFFF);
        send_sample(65536, -65536, 0, 0, Q_ONE, 0, 0, 0);
        send_sample(-32'sd5, 5, 32'hffffffff, 0, 0, Q_ONE, 0, 500);
        send_sample(1000, 2000, 3000, 0, 0, 0, Q_ONE, 2000);
        send_sample(32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'h55555555, 32'haaaaaaaa,
                    32'h33333333, 32'hcccccccc, 20'hAAAAA);
        send_sample(32'haaaaaaaa, 32'h55555555, 32'hedcba987, 32'haaaaaaaa, 32'h55555555,
                    32'hcccccccc, 32'h33333333, 20'h55555);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        send_directed();
        write_tau(20'h0);
        send_directed();
        send_sample(1, 2, 3, Q_ONE, 0, 0, 0, 0);
        write_tau(20'hFFFFF);
        send_directed();
        write_tau(1);
        send_random(300);
        hold_cycles = 3000;
        send_random(300);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        send_random(100);
        write_tau(20'($urandom));
        send_random(350);
        write_tau(20'(magr_pkg::TAU_RESET));
        send_random(350);
        write_tau(20'h0);
        send_random(150);
        write_tau(20'($urandom_range(1, 20000)));
        idle_on = 1'b0;
        send_random(300);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/magr_pkg.sv
hw/rtl/magr_mul.sv
hw/rtl/magr_div.sv
hw/rtl/motion_accel_gravity_removal.sv
bench/magr_checker.sv
bench/tb.sv
